@@ rtl/core/roi_stat_pkg.sv @@
// ----------------------------------------------------------------------------
// roi_stat_pkg
// Types and constants shared by the rectangle region statistics core.
// ----------------------------------------------------------------------------
package roi_stat_pkg;

    localparam int IMAGE_SIDE_DEF  = 512;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [18:0] COUNT_MAX  = 19'h7FFFF;
    localparam int          DIV_STEPS  = 65;
    localparam int          SQRT_STEPS = 24;

    // configuration register indexes
    localparam logic [2:0] CFG_COL_A = 3'd0;
    localparam logic [2:0] CFG_COL_B = 3'd1;
    localparam logic [2:0] CFG_ROW_A = 3'd2;
    localparam logic [2:0] CFG_ROW_B = 3'd3;
    localparam logic [2:0] CFG_AREA  = 3'd4;

    typedef struct packed {
        logic signed [15:0] pixel_value;
        logic [8:0]         column;
        logic [8:0]         row;
        logic               last_pixel;
    } t_in;

    typedef struct packed {
        logic               valid_res;
        logic [18:0]        pixel_count;
        logic signed [23:0] mean_q8;
        logic [23:0]        std_dev_q8;
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic [41:0]        area_q16;
    } t_out;

endpackage

@@ rtl/core/roi_rectangle_pixel_statistics_core.sv @@
// ----------------------------------------------------------------------------
// roi_rectangle_pixel_statistics_core
// Count, mean, deviation, min, max and area over an inclusive rectangle.
// ----------------------------------------------------------------------------
// Each pixel request passes through capture, square and accumulate, and the
// input takes a new pixel only once the previous one is through. A pixel
// marked last adds a result phase: a check step, two 65-step restoring
// divisions on one shared shift/subtract divider (mean, then mean square)
// with a multiply step between them, a 24-step square root with its load
// step, two further multiply steps (rectangle extent, area) and the step
// that loads the output register once it is free. All products go through
// one shared 24x24 multiplier. An empty rectangle skips the arithmetic and
// reports zeros with valid_res clear. The result sits in an output register
// until taken; the next slice may start meanwhile, and a further result
// waits until that register is free. Configuration writes are always ready
// and must only be made while the core is idle.
module roi_rectangle_pixel_statistics_core #(
    parameter int IMAGE_SIDE  = roi_stat_pkg::IMAGE_SIDE_DEF,
    parameter int SAMPLE_BITS = roi_stat_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  roi_stat_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output roi_stat_pkg::t_out o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam logic [12:0] SIDE_M1 = 13'(IMAGE_SIDE - 1);
    localparam logic signed [15:0] MIN_INIT = 16'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [15:0] MAX_INIT = 16'(-(1 << (SAMPLE_BITS - 1)));

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQR  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DIV1 = 4'd4;
    localparam logic [3:0] S_MSQ  = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_ISQ  = 4'd7;
    localparam logic [3:0] S_EXT  = 4'd8;
    localparam logic [3:0] S_AREA = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // configuration registers
    logic [8:0]  r_col_a, r_col_b, r_row_a, r_row_b;
    logic [23:0] r_pix_area;

    // sequencer and pixel capture
    logic [3:0]         r_state;
    logic [6:0]         r_cnt;
    logic signed [15:0] r_val;
    logic [8:0]         r_col, r_row;
    logic               r_last;

    // accumulators
    logic signed [34:0] r_sum;
    logic [48:0]        r_sqsum;
    logic signed [15:0] r_min, r_max;
    logic [18:0]        r_count;

    // shared arithmetic
    logic [47:0] r_prod;
    logic [64:0] r_dq;
    logic [19:0] r_rem;
    logic [23:0] r_mq;
    logic        r_neg;
    logic [47:0] r_sv, r_sres, r_sbit;
    logic        r_empty;

    // output register
    logic               r_ovalid;
    roi_stat_pkg::t_out r_out;

    // rectangle bounds, saturated to the image and ordered
    logic [12:0] ca, cb, ra, rb, clo, chi, rlo, rhi;
    logic [9:0]  ext_c, ext_r;
    logic        in_rect;

    always_comb begin
        ca  = ({4'd0, r_col_a} > SIDE_M1) ? SIDE_M1 : {4'd0, r_col_a};
        cb  = ({4'd0, r_col_b} > SIDE_M1) ? SIDE_M1 : {4'd0, r_col_b};
        ra  = ({4'd0, r_row_a} > SIDE_M1) ? SIDE_M1 : {4'd0, r_row_a};
        rb  = ({4'd0, r_row_b} > SIDE_M1) ? SIDE_M1 : {4'd0, r_row_b};
        clo = (ca < cb) ? ca : cb;
        chi = (ca < cb) ? cb : ca;
        rlo = (ra < rb) ? ra : rb;
        rhi = (ra < rb) ? rb : ra;
        ext_c = 10'(chi - clo + 13'd1);
        ext_r = 10'(rhi - rlo + 13'd1);
        in_rect = ({4'd0, r_col} <= SIDE_M1) && ({4'd0, r_row} <= SIDE_M1) &&
                  ({4'd0, r_col} >= clo) && ({4'd0, r_col} <= chi) &&
                  ({4'd0, r_row} >= rlo) && ({4'd0, r_row} <= rhi) &&
                  (r_count < roi_stat_pkg::COUNT_MAX);
    end

    // sample: low SAMPLE_BITS bits, sign-extended
    logic signed [SAMPLE_BITS-1:0] in_raw;
    logic signed [15:0]            in_val;
    logic [16:0]                   val_mag;
    assign in_raw  = i_in_data.pixel_value[SAMPLE_BITS-1:0];
    assign in_val  = 16'(in_raw);
    assign val_mag = r_val[15] ? (17'd0 - {r_val[15], r_val}) : {1'b0, r_val};

    // shared multiplier, operands chosen by the sequencer
    logic [23:0] mul_a, mul_b;
    logic [47:0] mul_p;
    always_comb begin
        case (r_state)
            S_SQR:   begin mul_a = {7'd0, val_mag};  mul_b = {7'd0, val_mag}; end
            S_MSQ:   begin mul_a = r_dq[23:0];       mul_b = r_dq[23:0];      end
            S_EXT:   begin mul_a = {14'd0, ext_c};   mul_b = {14'd0, ext_r};  end
            default: begin mul_a = r_prod[23:0];     mul_b = r_pix_area;      end
        endcase
        mul_p = mul_a * mul_b;
    end

    // shared divider step
    logic [19:0] div_t;
    logic        div_ge;
    assign div_t  = {r_rem[18:0], r_dq[64]};
    assign div_ge = div_t >= {1'b0, r_count};

    // square root step
    logic [47:0] sq_sum;
    assign sq_sum = r_sres + r_sbit;

    // sum magnitude for the mean, which is divided with half-divisor rounding
    logic [34:0] sum_mag;
    assign sum_mag = r_sum[34] ? 35'(-r_sum) : 35'(r_sum);

    // variance, clamped at zero
    logic [47:0] msq, var_q16;
    assign msq     = {1'b0, r_dq[46:0]};
    assign var_q16 = (msq > r_prod) ? (msq - r_prod) : 48'd0;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_a    <= 9'd0;
            r_col_b    <= 9'd511;
            r_row_a    <= 9'd0;
            r_row_b    <= 9'd511;
            r_pix_area <= 24'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                roi_stat_pkg::CFG_COL_A: r_col_a    <= i_cfg_data[8:0];
                roi_stat_pkg::CFG_COL_B: r_col_b    <= i_cfg_data[8:0];
                roi_stat_pkg::CFG_ROW_A: r_row_a    <= i_cfg_data[8:0];
                roi_stat_pkg::CFG_ROW_B: r_row_b    <= i_cfg_data[8:0];
                roi_stat_pkg::CFG_AREA:  r_pix_area <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 7'd0;
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_min    <= MIN_INIT;
            r_max    <= MAX_INIT;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the result once the consumer takes it
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_val   <= in_val;
                        r_col   <= i_in_data.column;
                        r_row   <= i_in_data.row;
                        r_last  <= i_in_data.last_pixel;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_prod  <= mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (in_rect) begin
                        r_sum   <= r_sum + 35'(r_val);
                        r_sqsum <= r_sqsum + {17'd0, r_prod[31:0]};
                        if (r_val < r_min) r_min <= r_val;
                        if (r_val > r_max) r_max <= r_val;
                        r_count <= r_count + 19'd1;
                    end
                    r_state <= r_last ? S_CHK : S_IDLE;
                end
                S_CHK: begin
                    r_empty <= (r_count == 19'd0);
                    r_neg   <= r_sum[34];
                    r_dq    <= {22'd0, sum_mag, 8'd0} + {47'd0, r_count[18:1]};
                    r_rem   <= '0;
                    r_cnt   <= 7'd0;
                    r_prod  <= '0;
                    r_state <= (r_count == 19'd0) ? S_DONE : S_DIV1;
                end
                S_DIV1, S_DIV2: begin
                    r_rem <= div_ge ? (div_t - {1'b0, r_count}) : div_t;
                    r_dq  <= {r_dq[63:0], div_ge};
                    if (r_cnt == 7'(roi_stat_pkg::DIV_STEPS - 1)) begin
                        r_cnt <= 7'd0;
                        if (r_state == S_DIV1) begin
                            r_state <= S_MSQ;
                        end else begin
                            r_state <= S_ISQ;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_MSQ: begin
                    // hold mean in r_mq, its square in r_prod; load mean square
                    r_mq    <= r_dq[23:0];
                    r_prod  <= mul_p;
                    r_dq    <= {r_sqsum, 16'd0};
                    r_rem   <= '0;
                    r_state <= S_DIV2;
                end
                S_ISQ: begin
                    if (r_cnt == 7'd0) begin
                        // load variance; first root step follows
                        r_sv   <= var_q16;
                        r_sres <= '0;
                        r_sbit <= 48'd1 << 46;
                        r_cnt  <= 7'd1;
                    end else begin
                        if (r_sv >= sq_sum) begin
                            r_sv   <= r_sv - sq_sum;
                            r_sres <= (r_sres >> 1) + r_sbit;
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                        r_cnt  <= r_cnt + 7'd1;
                        if (r_cnt == 7'(roi_stat_pkg::SQRT_STEPS)) r_state <= S_EXT;
                    end
                end
                S_EXT: begin
                    r_prod  <= mul_p;
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    r_prod  <= mul_p;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // wait for a free output register, then clear for next slice
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        if (r_empty) begin
                            r_out <= '0;
                        end else begin
                            r_out.valid_res   <= 1'b1;
                            r_out.pixel_count <= r_count;
                            r_out.mean_q8     <= r_neg ? (24'd0 - r_mq) : r_mq;
                            r_out.std_dev_q8  <= r_sres[23:0];
                            r_out.min_value   <= r_min;
                            r_out.max_value   <= r_max;
                            r_out.area_q16    <= r_prod[41:0];
                        end
                        r_sum   <= '0;
                        r_sqsum <= '0;
                        r_min   <= MIN_INIT;
                        r_max   <= MAX_INIT;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 || r_state == S_DIV2) |-> r_cnt < 7'(roi_stat_pkg::DIV_STEPS))
        else $error("divider step count overrun");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.valid_res) |-> (o_out_data.pixel_count == 19'd0 &&
        o_out_data.area_q16 == 42'd0))
        else $error("empty result carries data");
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.valid_res) |->
        (o_out_data.min_value <= o_out_data.max_value))
        else $error("minimum above maximum");
    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result overwrote pending output");
`endif

endmodule
